>>> rtl/core/gncsp_pkg.sv
// ----------------------------------------------------------------------------
// gncsp_pkg
// Shared constants, types and helpers for the grid shortest-path block.
// ----------------------------------------------------------------------------
package gncsp_pkg;

    localparam int MAX_ROWS  = 8;
    localparam int MAX_COLS  = 8;
    localparam int COST_BITS = 16;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int DIST_W    = 23;
    localparam int PATH_W    = 22;
    localparam int IN_W      = 16;
    localparam int OUT_IDX_W = 6;
    localparam int CFG_W     = 4;
    localparam int ADDR_W    = 3;

    localparam logic [DIST_W-1:0] INF_COST = {DIST_W{1'b1}};
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

    localparam logic [ADDR_W-1:0] REG_ROWS = 3'd0;
    localparam logic [ADDR_W-1:0] REG_COLS = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_INIT,
        ST_SEED,
        ST_SCAN,
        ST_PICK,
        ST_NBR_RD,
        ST_NBR_WR,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_all;   // reset count, start clearing pass
        logic clr_step;    // clear one entry, advance pointer
        logic load;        // store an input beat
        logic init;        // seed cell 0
        logic scan_start;
        logic scan_step;
        logic pick;        // finish chosen cell, start neighbor walk
        logic nbr_rd;      // read neighbor distance
        logic nbr_wr;      // relax neighbor, advance
        logic out_start;
        logic out_rd;
        logic out_show;
        logic out_next;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic load_done;
        logic scan_done;
        logic none_left;
        logic nbr_done;
        logic out_last;
        logic nbr_skip;
    } stat_t;

endpackage

>>> rtl/core/gncsp_stream_if.sv
// ----------------------------------------------------------------------------
// gncsp_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface gncsp_stream_if #(parameter int W = 16);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/gncsp_ram.sv
// ----------------------------------------------------------------------------
// gncsp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module gncsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/gncsp_ctrl.sv
// ----------------------------------------------------------------------------
// gncsp_ctrl
// Sequencer for clear, load, search and readout.
// ----------------------------------------------------------------------------
module gncsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr,
    input  logic             in_valid,
    input  logic             out_ready,
    input  gncsp_pkg::stat_t stat,
    output gncsp_pkg::cmd_t  cmd,
    output logic             in_ready,
    output logic             out_valid
);
    import gncsp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.load_done)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                // cost of cell 0 is read here, seeded next cycle
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                cmd.init       = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (stat.none_left)
                begin
                    cmd.out_start = 1'b1;
                    state_next    = ST_OUT_RD;
                end
                else
                begin
                    cmd.pick   = 1'b1;
                    state_next = ST_NBR_RD;
                end
            end
            ST_NBR_RD:
            begin
                if (stat.nbr_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
                else
                begin
                    cmd.nbr_rd = 1'b1;
                    state_next = ST_NBR_WR;
                end
            end
            ST_NBR_WR:
            begin
                cmd.nbr_wr = 1'b1;
                state_next = ST_NBR_RD;
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_show = 1'b1;
                out_valid    = 1'b1;
                if (out_ready)
                begin
                    if (stat.out_last)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_wr)
        begin
            cmd           = '0;
            cmd.clear_all = 1'b1;
            state_next    = ST_CLEAR;
        end
    end
endmodule

>>> rtl/core/gncsp_dpath.sv
// ----------------------------------------------------------------------------
// gncsp_dpath
// Cost and distance memories, finished flags, scan and relax logic.
// ----------------------------------------------------------------------------
module gncsp_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gncsp_pkg::cmd_t                    cmd,
    input  logic [gncsp_pkg::CFG_W-1:0]        rows,
    input  logic [gncsp_pkg::CFG_W-1:0]        cols,
    input  logic [gncsp_pkg::IN_W-1:0]         cost,
    output gncsp_pkg::stat_t                   stat,
    output logic [gncsp_pkg::OUT_IDX_W-1:0]    cell_index,
    output logic [gncsp_pkg::PATH_W-1:0]       path_cost,
    output logic                               last
);
    import gncsp_pkg::*;

    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);

    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    logic [CNT_W-1:0] total;

    always_comb
    begin
        if (rows == '0)
            nr = RW'(1);
        else if (32'(rows) > MAX_ROWS)
            nr = RW'(MAX_ROWS);
        else
            nr = RW'(rows);
        if (cols == '0)
            nc = CW'(1);
        else if (32'(cols) > MAX_COLS)
            nc = CW'(MAX_COLS);
        else
            nc = CW'(cols);
    end

    // total registered; config must only change while idle, which the block does not enforce
    logic [CNT_W-1:0] total_reg;
    always_ff @(posedge clk)
    begin
        total_reg <= CNT_W'(nr) * CNT_W'(nc);
    end
    assign total = total_reg;

    logic [CNT_W-1:0]  ptr_reg;
    logic [RW-1:0]     lrow_reg;
    logic [CW-1:0]     lcol_reg;
    logic [IDX_W-1:0]  lbase_reg;
    logic [IDX_W-1:0]  u_reg;
    logic [RW-1:0]     ur_reg;
    logic [CW-1:0]     uc_reg;
    logic [RW-1:0]     sr_reg;
    logic [CW-1:0]     sc_reg;
    logic [DIST_W-1:0] bestv_reg;
    logic              found_reg;
    logic [DIST_W-1:0] du_reg;
    logic [2:0]        nb_reg;
    logic [IDX_W-1:0]  nidx_reg;
    logic              nvalid_reg;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  ptr_d_reg;

    // memories; distance entries carry the finished flag in their top bit
    logic              c_we, d_we;
    logic [IDX_W-1:0]  c_addr, d_addr;
    logic [COST_BITS-1:0] c_wdata, c_rdata;
    logic [DIST_W:0]   d_wdata, d_rdata;
    logic              d_fin;
    logic [DIST_W-1:0] d_val;

    gncsp_ram #(.WIDTH(COST_BITS), .DEPTH(CELLS)) u_cost (
        .clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
    );
    gncsp_ram #(.WIDTH(DIST_W + 1), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
    );

    assign d_fin = d_rdata[DIST_W];
    assign d_val = d_rdata[DIST_W-1:0];

    // neighbor candidate for current nb_reg
    logic              nb_ok;
    logic [IDX_W-1:0]  nb_idx;
    always_comb
    begin
        nb_ok  = 1'b0;
        nb_idx = u_reg;
        case (nb_reg)
            3'd0:
            begin
                nb_ok  = (uc_reg != '0);
                nb_idx = u_reg - IDX_W'(1);
            end
            3'd1:
            begin
                nb_ok  = (32'(uc_reg) + 1 < 32'(nc));
                nb_idx = u_reg + IDX_W'(1);
            end
            3'd2:
            begin
                nb_ok  = (ur_reg != '0);
                nb_idx = u_reg - IDX_W'(nc);
            end
            3'd3:
            begin
                nb_ok  = (32'(ur_reg) + 1 < 32'(nr));
                nb_idx = u_reg + IDX_W'(nc);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    logic [DIST_W:0]   cand;
    logic [DIST_W-1:0] cand_sat;
    assign cand     = {1'b0, du_reg} + (DIST_W+1)'(c_rdata);
    assign cand_sat = cand[DIST_W] ? INF_COST : cand[DIST_W-1:0];

    logic [DIST_W-1:0] c0_ext;
    assign c0_ext = DIST_W'(c_rdata);

    logic scan_hit;
    assign scan_hit = rd_pend_reg && !d_fin
                      && (!found_reg || d_val < bestv_reg);

    // memory addressing
    always_comb
    begin
        c_we    = 1'b0;
        d_we    = 1'b0;
        c_addr  = ptr_reg[IDX_W-1:0];
        d_addr  = ptr_reg[IDX_W-1:0];
        c_wdata = COST_BITS'(cost);
        d_wdata = {1'b0, INF_COST};
        if (cmd.clr_step)
        begin
            d_we = 1'b1;
        end
        else if (cmd.load)
        begin
            c_we   = 1'b1;
            c_addr = lbase_reg + IDX_W'(lcol_reg);
        end
        else if (cmd.init)
        begin
            d_we    = 1'b1;
            d_addr  = '0;
            d_wdata = {1'b0, c0_ext};
        end
        else if (cmd.pick)
        begin
            d_we    = 1'b1;
            d_addr  = u_reg;
            d_wdata = {1'b1, bestv_reg};
        end
        else if (cmd.nbr_rd)
        begin
            c_addr = nidx_reg;
            d_addr = nidx_reg;
        end
        else if (cmd.nbr_wr)
        begin
            d_addr  = nidx_reg;
            d_wdata = {1'b0, cand_sat};
            d_we    = nvalid_reg && !d_fin && (d_val > cand_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
            nb_reg      <= '0;
            lrow_reg    <= '0;
            lcol_reg    <= '0;
            lbase_reg   <= '0;
        end
        else
        begin
            rd_pend_reg <= 1'b0;
            if (cmd.clear_all)
            begin
                ptr_reg <= '0;
            end
            if (cmd.clr_step)
            begin
                ptr_reg  <= ptr_reg + CNT_W'(1);
                lrow_reg <= nr - RW'(1);
                lcol_reg <= '0;
                lbase_reg <= IDX_W'(nr - RW'(1)) * IDX_W'(nc);
                if (stat.clr_done)
                    ptr_reg <= '0;
            end
            if (cmd.load)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
                if (32'(lcol_reg) + 1 >= 32'(nc))
                begin
                    lcol_reg  <= '0;
                    lrow_reg  <= lrow_reg - RW'(1);
                    lbase_reg <= lbase_reg - IDX_W'(nc);
                end
                else
                begin
                    lcol_reg <= lcol_reg + CW'(1);
                end
                if (stat.load_done)
                    ptr_reg <= '0;
            end
            if (cmd.scan_start)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
                sr_reg    <= '0;
                sc_reg    <= '0;
            end
            if (cmd.scan_step)
            begin
                if (ptr_reg < total)
                begin
                    ptr_reg     <= ptr_reg + CNT_W'(1);
                    rd_pend_reg <= 1'b1;
                    ptr_d_reg   <= ptr_reg[IDX_W-1:0];
                end
                if (scan_hit)
                begin
                    found_reg <= 1'b1;
                    bestv_reg <= d_val;
                    u_reg     <= ptr_d_reg;
                    ur_reg    <= sr_reg;
                    uc_reg    <= sc_reg;
                end
                if (rd_pend_reg)
                begin
                    if (32'(sc_reg) + 1 >= 32'(nc))
                    begin
                        sc_reg <= '0;
                        sr_reg <= sr_reg + RW'(1);
                    end
                    else
                    begin
                        sc_reg <= sc_reg + CW'(1);
                    end
                end
            end
            if (cmd.pick)
            begin
                du_reg <= bestv_reg;
                nb_reg <= (bestv_reg == INF_COST) ? 3'd4 : 3'd0;
            end
            if (cmd.nbr_rd)
            begin
                nb_reg <= nb_reg + 3'd1;
            end
            if (cmd.out_start)
            begin
                ptr_reg <= '0;
            end
            if (cmd.out_next)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
        end
    end

    // neighbor index registered one step ahead of its read
    always_ff @(posedge clk)
    begin
        if (cmd.pick || cmd.nbr_wr)
        begin
            nidx_reg   <= nb_idx;
            nvalid_reg <= nb_ok;
        end
        if (cmd.pick)
        begin
            // nb_reg not yet updated: compute for first neighbor (west)
            nidx_reg   <= u_reg - IDX_W'(1);
            nvalid_reg <= (uc_reg != '0);
        end
    end

    always_comb
    begin
        stat           = '0;
        stat.clr_done  = (ptr_reg == CNT_W'(CELLS - 1));
        stat.load_done = (ptr_reg + CNT_W'(1) >= total);
        stat.scan_done = (ptr_reg >= total) && !rd_pend_reg;
        stat.none_left = !found_reg;
        stat.nbr_done  = (nb_reg >= 3'd4);
        stat.out_last  = (ptr_reg + CNT_W'(1) >= total);
        stat.nbr_skip  = !nvalid_reg;
    end

    assign cell_index = OUT_IDX_W'(ptr_reg);
    assign path_cost  = (d_val > DIST_W'(PATH_MAX)) ? PATH_MAX : d_val[PATH_W-1:0];
    assign last       = stat.out_last;
endmodule

>>> rtl/core/grid_node_cost_shortest_path.sv
// ----------------------------------------------------------------------------
// grid_node_cost_shortest_path
// Grid shortest path over node entrance costs, Dijkstra with linear scan.
// ----------------------------------------------------------------------------
// Usage: program rows and cols over APB (byte addresses 0 and 4) while idle;
// a write drops any partial load. Send rows*cols cost beats on the input
// channel, highest row index first, each row left to right. After the final
// beat the block reads and then seeds the cost of cell 0, then runs Dijkstra
// from it: each of the N cells costs one scan over the distance RAM, one pick
// and the relaxing of up to four neighbors; the single-port distance memory
// bounds the search. Results then leave as N beats in index order, each read
// from the distance RAM before it is shown, with last on the final cell.
// While the receiver stalls, the current beat holds. No input is taken during
// search or readout. After reset, and after every set or configuration write,
// a clearing pass over all 64 distance entries resets the distances and
// finished flags before loads resume.
// ----------------------------------------------------------------------------
module grid_node_cost_shortest_path (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gncsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    gncsp_stream_if.sink                    cost_in,
    gncsp_stream_if.source                  result_out
);
    import gncsp_pkg::*;

    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    stat_t            stat;
    logic [OUT_IDX_W-1:0] cell_index;
    logic [PATH_W-1:0]    path_cost;
    logic                 last;

    assign pready = 1'b1;
    // any completed write restarts the set; unknown addresses just clear
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(8);
            cols_reg <= CFG_W'(8);
        end
        else if (cfg_wr)
        begin
            if (paddr == REG_ROWS)
                rows_reg <= pwdata[CFG_W-1:0];
            else if (paddr == REG_COLS)
                cols_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr)
            REG_ROWS: prdata = 32'(rows_reg);
            REG_COLS: prdata = 32'(cols_reg);
            default:  prdata = '0;
        endcase
    end

    gncsp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_wr(cfg_wr),
        .in_valid(cost_in.valid), .out_ready(result_out.ready),
        .stat(stat), .cmd(cmd),
        .in_ready(cost_in.ready), .out_valid(result_out.valid)
    );

    gncsp_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .rows(rows_reg), .cols(cols_reg), .cost(cost_in.data[IN_W-1:0]),
        .stat(stat), .cell_index(cell_index), .path_cost(path_cost), .last(last)
    );

    // payload: {cell_index, path_cost, last}
    assign result_out.data = {cell_index, path_cost, last};
endmodule
